// ===== hdl/pps_pkg.sv =====
`timescale 1ns / 1ps

package pps_pkg;

   // Item kinds carried on req_tuser.
   localparam logic [1:0] FUNC_CLEAR  = 2'd0;
   localparam logic [1:0] FUNC_APPEND = 2'd1;
   localparam logic [1:0] FUNC_TICK   = 2'd2;

   localparam int unsigned TIME_W  = 16;
   localparam int unsigned PRIO_W  = 8;
   localparam int unsigned CLOCK_W = 32;
   localparam int unsigned OUT_IDX_W = 4;

   // One row of the task table.
   typedef struct packed {
      logic [TIME_W-1:0] arrival;
      logic [TIME_W-1:0] remaining;
      logic [PRIO_W-1:0] prio;
   } entry_type;

endpackage

// ===== hdl/pps_ram.sv =====
`timescale 1ns / 1ps

module pps_ram #(
   parameter int unsigned WIDTH = 40,
   parameter int unsigned DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/preemptive_priority_scheduler.sv =====
`timescale 1ns / 1ps

// Preemptive priority scheduler. The block keeps a table of up to MAX_TASKS tasks in a
// single-port-read RAM and handles one item at a time: req_tuser selects clear, append or
// tick. Clear and append go from the accepting cycle to the state that loads the result
// register. On a tick, one comparator walks the table one entry per cycle through the RAM
// read port, picking the eligible task of highest priority (earlier arrival, then lower
// index, breaks ties). Once the registered read drains, the update state writes back the
// decremented run time and the response state loads the result register. req_tready is
// high only while the sequencer is idle; a finished result waits in the output register, so
// the next item may be taken while the result is still stalled.
module preemptive_priority_scheduler #(
   parameter int unsigned MAX_TASKS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [15:0] arrival_time, [31:16] burst_time, [39:32] priority_level
   input  logic [39:0] req_tdata,
   // [1:0] func
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [0] task_valid, [4:1] task_index, [5] segment_start, [37:6] tick_time,
   // [38] all_done, [39] table_full
   output logic [39:0] rsp_tdata
);

   localparam int unsigned IDX_W = $clog2(MAX_TASKS);
   localparam int unsigned CNT_W = $clog2(MAX_TASKS + 1);
   localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_TASKS);
   localparam int unsigned ENTRY_W = $bits(pps_pkg::entry_type);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SCAN   = 2'd1;
   localparam logic [1:0] ST_UPDATE = 2'd2;
   localparam logic [1:0] ST_RESP   = 2'd3;

   logic [1:0] state_ff, state_in;
   logic [CNT_W-1:0] task_count_ff, task_count_in;
   logic [CNT_W-1:0] finished_ff, finished_in;
   logic [pps_pkg::CLOCK_W-1:0] time_ff, time_in;
   logic prev_valid_ff, prev_valid_in;
   logic [IDX_W-1:0] prev_idx_ff, prev_idx_in;

   logic [CNT_W-1:0] iss_ff, iss_in;
   logic rd_valid_ff, rd_valid_in;
   logic [IDX_W-1:0] rd_idx_ff, rd_idx_in;
   logic best_valid_ff, best_valid_in;
   logic [IDX_W-1:0] best_idx_ff, best_idx_in;
   pps_pkg::entry_type best_ff, best_in;

   logic res_valid_ff, res_valid_in;
   logic [pps_pkg::OUT_IDX_W-1:0] res_idx_ff, res_idx_in;
   logic res_seg_ff, res_seg_in;
   logic [pps_pkg::CLOCK_W-1:0] res_tick_ff, res_tick_in;
   logic res_full_ff, res_full_in;

   logic rsp_valid_ff, rsp_valid_in;
   logic [39:0] rsp_data_ff, rsp_data_in;

   logic ram_we, ram_re;
   logic [IDX_W-1:0] ram_waddr;
   pps_pkg::entry_type ram_wdata, ram_rdata, req_entry;
   logic [ENTRY_W-1:0] ram_rdata_raw;

   logic eligible, beats;
   logic [IDX_W+pps_pkg::OUT_IDX_W-1:0] best_idx_ext;

   assign req_entry.arrival   = req_tdata[15:0];
   assign req_entry.remaining = req_tdata[31:16];
   assign req_entry.prio      = req_tdata[39:32];

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   pps_ram #(
      .WIDTH(ENTRY_W),
      .DEPTH(MAX_TASKS)
   ) u_table (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(ram_waddr),
      .wr_data(ram_wdata),
      .rd_en  (ram_re),
      .rd_addr(iss_ff[IDX_W-1:0]),
      .rd_data(ram_rdata_raw)
   );

   assign ram_rdata = pps_pkg::entry_type'(ram_rdata_raw);

   // A task competes once it has arrived and still has run time left.
   assign eligible = (ram_rdata.remaining != '0) &&
                     ({{(pps_pkg::CLOCK_W-pps_pkg::TIME_W){1'b0}}, ram_rdata.arrival} <= time_ff);
   // Entries come in index order, so a strict compare leaves equal ties with the lower index.
   assign beats = !best_valid_ff ||
                  (ram_rdata.prio > best_ff.prio) ||
                  ((ram_rdata.prio == best_ff.prio) && (ram_rdata.arrival < best_ff.arrival));

   assign best_idx_ext = {{pps_pkg::OUT_IDX_W{1'b0}}, best_idx_ff};

   always_comb begin
      state_in      = state_ff;
      task_count_in = task_count_ff;
      finished_in   = finished_ff;
      time_in       = time_ff;
      prev_valid_in = prev_valid_ff;
      prev_idx_in   = prev_idx_ff;
      iss_in        = iss_ff;
      rd_valid_in   = rd_valid_ff;
      rd_idx_in     = rd_idx_ff;
      best_valid_in = best_valid_ff;
      best_idx_in   = best_idx_ff;
      best_in       = best_ff;
      res_valid_in  = res_valid_ff;
      res_idx_in    = res_idx_ff;
      res_seg_in    = res_seg_ff;
      res_tick_in   = res_tick_ff;
      res_full_in   = res_full_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      ram_we        = 1'b0;
      ram_re        = 1'b0;
      ram_waddr     = task_count_ff[IDX_W-1:0];
      ram_wdata     = req_entry;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               res_valid_in = 1'b0;
               res_idx_in   = '0;
               res_seg_in   = 1'b0;
               res_full_in  = 1'b0;
               res_tick_in  = time_ff;
               state_in     = ST_RESP;
               case (req_tuser)
                  pps_pkg::FUNC_CLEAR: begin
                     task_count_in = '0;
                     finished_in   = '0;
                     time_in       = '0;
                     prev_valid_in = 1'b0;
                     res_tick_in   = '0;
                  end
                  pps_pkg::FUNC_APPEND: begin
                     if (task_count_ff >= MAX_CNT) begin
                        res_full_in = 1'b1;
                     end else begin
                        ram_we        = 1'b1;
                        task_count_in = task_count_ff + 1'b1;
                        if (req_entry.remaining == '0) begin
                           finished_in = finished_ff + 1'b1;
                        end
                     end
                  end
                  pps_pkg::FUNC_TICK: begin
                     iss_in        = '0;
                     rd_valid_in   = 1'b0;
                     best_valid_in = 1'b0;
                     state_in      = ST_SCAN;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SCAN: begin
            rd_valid_in = 1'b0;
            if (iss_ff != task_count_ff) begin
               ram_re      = 1'b1;
               iss_in      = iss_ff + 1'b1;
               rd_valid_in = 1'b1;
               rd_idx_in   = iss_ff[IDX_W-1:0];
            end
            if (rd_valid_ff && eligible && beats) begin
               best_valid_in = 1'b1;
               best_idx_in   = rd_idx_ff;
               best_in       = ram_rdata;
            end
            if ((iss_ff == task_count_ff) && !rd_valid_ff) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            res_tick_in   = time_ff;
            res_valid_in  = best_valid_ff;
            res_idx_in    = '0;
            res_seg_in    = 1'b0;
            prev_valid_in = best_valid_ff;
            prev_idx_in   = best_idx_ff;
            if (best_valid_ff) begin
               ram_we              = 1'b1;
               ram_waddr           = best_idx_ff;
               ram_wdata           = best_ff;
               ram_wdata.remaining = best_ff.remaining - 1'b1;
               if (best_ff.remaining == pps_pkg::TIME_W'(1)) begin
                  finished_in = finished_ff + 1'b1;
               end
               res_idx_in = best_idx_ext[pps_pkg::OUT_IDX_W-1:0];
               res_seg_in = !prev_valid_ff || (prev_idx_ff != best_idx_ff);
            end
            if (time_ff != '1) begin
               time_in = time_ff + 1'b1;
            end
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {res_full_ff, (finished_ff == task_count_ff), res_tick_ff,
                               res_seg_ff, res_idx_ff, res_valid_ff};
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         task_count_ff <= '0;
         finished_ff   <= '0;
         time_ff       <= '0;
         prev_valid_ff <= 1'b0;
         rd_valid_ff   <= 1'b0;
         best_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         task_count_ff <= task_count_in;
         finished_ff   <= finished_in;
         time_ff       <= time_in;
         prev_valid_ff <= prev_valid_in;
         rd_valid_ff   <= rd_valid_in;
         best_valid_ff <= best_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      prev_idx_ff  <= prev_idx_in;
      iss_ff       <= iss_in;
      rd_idx_ff    <= rd_idx_in;
      best_idx_ff  <= best_idx_in;
      best_ff      <= best_in;
      res_valid_ff <= res_valid_in;
      res_idx_ff   <= res_idx_in;
      res_seg_ff   <= res_seg_in;
      res_tick_ff  <= res_tick_in;
      res_full_ff  <= res_full_in;
      rsp_data_ff  <= rsp_data_in;
   end

endmodule

// ===== hdl/pps_checker.sv =====
`timescale 1ns / 1ps

module pps_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [39:0] rsp_tdata
);

   // A stalled result must hold still.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // One item at a time: the block is busy in the cycle after it takes an item.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("item accepted while previous item still in work");

   // A new segment can only start on a tick that ran a task.
   a_seg_needs_task: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[5] |-> rsp_tdata[0])
      else $error("segment start without a running task");

   // A refused append never reports a running task.
   a_full_no_task: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[39] |-> !rsp_tdata[0] && (rsp_tdata[4:1] == 4'd0))
      else $error("table full reported together with a task");

endmodule

bind preemptive_priority_scheduler pps_checker u_pps_checker (
   .clock     (clock),
   .reset     (reset),
   .req_tvalid(req_tvalid),
   .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata (rsp_tdata)
);

// ===== verif/preemptive_priority_scheduler_tb.sv =====
`timescale 1ns / 1ps

module preemptive_priority_scheduler_tb;

   localparam int unsigned MAX_TASKS   = 16;
   localparam int          ITEM_TARGET = 1650;
   localparam logic [1:0]  FUNC_UNUSED = 2'd3;
   localparam int unsigned TIME_W      = pps_pkg::TIME_W;
   localparam int unsigned PRIO_W      = pps_pkg::PRIO_W;
   localparam int unsigned CLOCK_W     = pps_pkg::CLOCK_W;
   localparam int unsigned OUT_IDX_W   = pps_pkg::OUT_IDX_W;

   typedef struct packed {
      logic                 task_valid;
      logic [OUT_IDX_W-1:0] task_index;
      logic                 segment_start;
      logic [CLOCK_W-1:0]   tick_time;
      logic                 all_done;
      logic                 table_full;
   } sched_result_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   // [15:0] arrival_time, [31:16] burst_time, [39:32] priority_level
   logic [39:0] req_tdata;
   // [1:0] func
   logic [1:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   // [0] task_valid, [4:1] task_index, [5] segment_start, [37:6] tick_time,
   // [38] all_done, [39] table_full
   logic [39:0] rsp_tdata;

   // Scheduler state as the testbench predicts it.
   logic [TIME_W-1:0]  arrival_tbl   [MAX_TASKS];
   logic [TIME_W-1:0]  remaining_tbl [MAX_TASKS];
   logic [PRIO_W-1:0]  priority_tbl  [MAX_TASKS];
   int                 loaded_tasks;
   int                 done_tasks;
   logic [CLOCK_W-1:0] sched_time;
   int                 last_choice;

   sched_result_type expected_results[$];
   int  fail_count;
   int  items_sent;
   int  tick_items;
   int  idle_ticks;
   int  refused_appends;
   int  schedules;
   bit  steady_flow;

   preemptive_priority_scheduler #(.MAX_TASKS(MAX_TASKS)) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Works out the result of one item and moves the predicted state on.
   function automatic sched_result_type schedule_step(input logic [1:0] func,
                                                      input logic [TIME_W-1:0] arrival,
                                                      input logic [TIME_W-1:0] burst,
                                                      input logic [PRIO_W-1:0] prio);
      sched_result_type res;
      int best;
      int i;
      res = '0;
      res.tick_time = sched_time;
      case (func)
         pps_pkg::FUNC_CLEAR: begin
            loaded_tasks = 0;
            done_tasks = 0;
            sched_time = '0;
            last_choice = -1;
            res.tick_time = '0;
         end
         pps_pkg::FUNC_APPEND: begin
            if (loaded_tasks >= MAX_TASKS) begin
               res.table_full = 1'b1;
            end else begin
               arrival_tbl[loaded_tasks] = arrival;
               remaining_tbl[loaded_tasks] = burst;
               priority_tbl[loaded_tasks] = prio;
               loaded_tasks++;
               // A task with no run time counts as finished straight away.
               if (burst == '0) done_tasks++;
            end
         end
         pps_pkg::FUNC_TICK: begin
            best = -1;
            for (i = 0; i < loaded_tasks; i++) begin
               if (remaining_tbl[i] != '0 && CLOCK_W'(arrival_tbl[i]) <= sched_time) begin
                  // Strict comparisons keep the lower index on a full tie.
                  if (best < 0 || priority_tbl[i] > priority_tbl[best] ||
                      (priority_tbl[i] == priority_tbl[best] &&
                       arrival_tbl[i] < arrival_tbl[best]))
                     best = i;
               end
            end
            if (best >= 0) begin
               res.task_valid = 1'b1;
               res.task_index = best[OUT_IDX_W-1:0];
               res.segment_start = (best != last_choice);
               remaining_tbl[best] = remaining_tbl[best] - 1'b1;
               if (remaining_tbl[best] == '0) done_tasks++;
            end
            last_choice = best;
            if (sched_time != '1) sched_time = sched_time + 1'b1;
         end
         default: ;
      endcase
      res.all_done = (done_tasks == loaded_tasks);
      return res;
   endfunction

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         fail_count++;
      end
   endfunction

   // Presents one item, leaves tvalid high on return so back-to-back items need no gap.
   task automatic send_item(input logic [1:0] func, input logic [TIME_W-1:0] arrival,
                            input logic [TIME_W-1:0] burst, input logic [PRIO_W-1:0] prio);
      int gap;
      sched_result_type want;
      gap = steady_flow ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser = func;
      req_tdata = {prio, burst, arrival};
      do @(posedge clock); while (!req_tready);
      want = schedule_step(func, arrival, burst, prio);
      expected_results.push_back(want);
      if (func != FUNC_UNUSED) items_sent++;
      if (func == pps_pkg::FUNC_TICK) begin
         tick_items++;
         if (!want.task_valid) idle_ticks++;
      end
      if (want.table_full) refused_appends++;
      @(negedge clock);
   endtask

   task automatic send_noise();
      send_item(2'($urandom_range(0, 3)), TIME_W'($urandom), TIME_W'($urandom),
                PRIO_W'($urandom));
   endtask

   task automatic test_directed();
      int k;
      send_item(pps_pkg::FUNC_CLEAR, 16'hffff, 16'hffff, 8'hff);
      send_item(pps_pkg::FUNC_TICK, '0, '0, '0);            // empty table gives an idle tick
      send_item(FUNC_UNUSED, 16'h1234, 16'h5678, 8'h9a);
      send_item(pps_pkg::FUNC_APPEND, 16'd0, 16'd0, 8'd255); // zero burst, finished on arrival
      send_item(pps_pkg::FUNC_APPEND, 16'd0, 16'd2, 8'd0);   // priority zero is still eligible
      send_item(pps_pkg::FUNC_APPEND, 16'hffff, 16'hffff, 8'hff);
      send_item(pps_pkg::FUNC_APPEND, 16'd1, 16'd1, 8'd7);
      send_item(pps_pkg::FUNC_APPEND, 16'd1, 16'd1, 8'd7);   // full tie, lower index should win
      send_item(pps_pkg::FUNC_APPEND, 16'd0, 16'd1, 8'd7);   // same priority, earlier arrival
      for (k = 0; k < 7; k++) send_item(pps_pkg::FUNC_TICK, '0, '0, '0);
   endtask

   task automatic test_table_full();
      int k;
      steady_flow = 1'b1;
      send_item(pps_pkg::FUNC_CLEAR, '0, '0, '0);
      // Priority rises with the index so that the upper entries get picked.
      for (k = 0; k < MAX_TASKS; k++)
         send_item(pps_pkg::FUNC_APPEND, TIME_W'(k % 3), TIME_W'(1 + k % 2),
                   PRIO_W'(k * 16));
      send_item(pps_pkg::FUNC_APPEND, 16'd0, 16'd5, 8'hff);
      send_item(pps_pkg::FUNC_APPEND, 16'hffff, 16'hffff, 8'hff);
      for (k = 0; k < 4; k++) send_item(pps_pkg::FUNC_TICK, '0, '0, '0);
      steady_flow = 1'b0;
   endtask

   // Mostly clear, load a random task set, tick until it drains or a limit is hit, with some noise.
   task automatic test_random_schedules();
      int n_tasks;
      int ticks;
      int tick_limit;
      int k;
      logic [TIME_W-1:0] arrival;
      logic [TIME_W-1:0] burst;
      logic [PRIO_W-1:0] prio;
      while (items_sent < ITEM_TARGET) begin
         steady_flow = ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 7) != 0)
            send_item(pps_pkg::FUNC_CLEAR, TIME_W'($urandom), TIME_W'($urandom),
                      PRIO_W'($urandom));
         n_tasks = $urandom_range(1, MAX_TASKS + 2);
         for (k = 0; k < n_tasks; k++) begin
            if ($urandom_range(0, 9) == 0) send_noise();
            arrival = ($urandom_range(0, 9) == 0) ? TIME_W'($urandom)
                                                  : TIME_W'($urandom_range(0, 12));
            case ($urandom_range(0, 9))
               0:       burst = TIME_W'($urandom);
               1:       burst = '0;
               default: burst = TIME_W'($urandom_range(1, 6));
            endcase
            prio = ($urandom_range(0, 2) == 0) ? PRIO_W'($urandom)
                                               : PRIO_W'($urandom_range(0, 3));
            send_item(pps_pkg::FUNC_APPEND, arrival, burst, prio);
         end
         ticks = 0;
         tick_limit = $urandom_range(20, 60);
         while (done_tasks != loaded_tasks && ticks < tick_limit) begin
            if ($urandom_range(0, 19) == 0) send_noise();
            send_item(pps_pkg::FUNC_TICK, TIME_W'($urandom), TIME_W'($urandom),
                      PRIO_W'($urandom));
            ticks++;
         end
         repeat ($urandom_range(0, 2)) send_item(pps_pkg::FUNC_TICK, '0, '0, '0);
         schedules++;
      end
      steady_flow = 1'b0;
   endtask

   // Result side: unless the flow is steady, hold rsp_tready low for a random stall before each result.
   initial begin : result_ready
      int stall;
      rsp_tready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         stall = steady_flow ? 0 : $urandom_range(0, 9);
         if (stall > 0) begin
            rsp_tready = 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready = 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         @(negedge clock);
      end
   end

   always @(posedge clock) begin : result_check
      sched_result_type want;
      sched_result_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.task_valid    = rsp_tdata[0];
         got.task_index    = rsp_tdata[4:1];
         got.segment_start = rsp_tdata[5];
         got.tick_time     = rsp_tdata[37:6];
         got.all_done      = rsp_tdata[38];
         got.table_full    = rsp_tdata[39];
         if (expected_results.size() == 0) begin
            $display("%0t: result with nothing expected, expected none, actual %0h",
                     $time, rsp_tdata);
            fail_count++;
         end else begin
            want = expected_results.pop_front();
            check_field("task_valid", 32'(want.task_valid), 32'(got.task_valid));
            check_field("task_index", 32'(want.task_index), 32'(got.task_index));
            check_field("segment_start", 32'(want.segment_start), 32'(got.segment_start));
            check_field("tick_time", want.tick_time, got.tick_time);
            check_field("all_done", 32'(want.all_done), 32'(got.all_done));
            check_field("table_full", 32'(want.table_full), 32'(got.table_full));
         end
      end
   end

   initial begin : main
      int wait_cycles;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = pps_pkg::FUNC_CLEAR;
      fail_count = 0;
      items_sent = 0;
      tick_items = 0;
      idle_ticks = 0;
      refused_appends = 0;
      schedules = 0;
      steady_flow = 1'b0;
      loaded_tasks = 0;
      done_tasks = 0;
      sched_time = '0;
      last_choice = -1;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed();
      test_table_full();
      test_random_schedules();
      req_tvalid = 1'b0;

      wait_cycles = 0;
      while (expected_results.size() != 0 && wait_cycles < 5000) begin
         @(posedge clock);
         wait_cycles++;
      end
      if (expected_results.size() != 0) begin
         $display("%0t: %0d results never arrived", $time, expected_results.size());
         fail_count++;
      end
      repeat (25) @(posedge clock);

      $display("Covered %0d items over %0d random schedules: %0d ticks (%0d idle),",
               items_sent, schedules, tick_items, idle_ticks);
      $display("%0d appends refused on a full table, %0d failures.",
               refused_appends, fail_count);
      if (fail_count == 0)
         $display("preemptive_priority_scheduler test passed");
      else
         $display("preemptive_priority_scheduler test failed");
      $finish;
   end

   initial begin : watchdog
      #5_000_000;
      $display("%0t: timed out", $time);
      $display("preemptive_priority_scheduler test failed");
      $finish;
   end

endmodule

// ===== sim.f =====
hdl/pps_pkg.sv
hdl/pps_ram.sv
hdl/preemptive_priority_scheduler.sv
hdl/pps_checker.sv
verif/preemptive_priority_scheduler_tb.sv
